[rtl/mps_pkg.sv]
// Shared constants, types and the arctangent table of the M-PSK phase slicer.
`default_nettype none

package mps_pkg;

    localparam int SAMPLE_WIDTH   = 24;
    localparam int MAX_BITS       = 6;
    localparam int BPS_W          = 3;
    localparam int PRESCALE_SHIFT = 8;
    localparam int XW             = SAMPLE_WIDTH + PRESCALE_SHIFT + 3;
    localparam int CORDIC_STEPS   = 16;
    localparam int ZW             = 20;
    localparam int ANGLE_W        = 16;
    localparam int SHAMT_W        = $clog2(ANGLE_W + 1);
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    localparam logic [ZW-1:0]      HALF_TURN_Z   = ZW'(1) << (ZW - 1);
    localparam logic [ZW-1:0]      Z_ROUND       = ZW'(1) << (ZW - ANGLE_W - 1);
    localparam logic [ANGLE_W-1:0] ANGLE_QUARTER = ANGLE_W'(1) << (ANGLE_W - 2);
    localparam logic [ANGLE_W-1:0] ANGLE_3QUARTER = ANGLE_W'(3) << (ANGLE_W - 2);
    localparam logic [BPS_W-1:0]   BPS_RESET     = BPS_W'(2);

    localparam logic [APB_AW-3:0]  REG_BPS = '0;

    // atan(2^-i) in units of 2^-20 turn
    localparam logic [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        20'd131072, 20'd77376, 20'd40883, 20'd20753,
        20'd10417,  20'd5213,  20'd2607,  20'd1304,
        20'd652,    20'd326,   20'd163,   20'd81,
        20'd41,     20'd20,    20'd10,    20'd5
    };

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [MAX_BITS-1:0]            symbol_t;
    typedef logic [BPS_W-1:0]               bps_t;

    typedef struct packed {
        logic [ZW-1:0] z;
        logic          xzero;
        logic          yneg;
    } cword_t;

endpackage

`default_nettype wire

[rtl/mps_ifs.sv]
// Valid/ready channel interfaces for correlator samples and symbol decisions.
`default_nettype none

interface mps_sample_if import mps_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t in_phase;
    sample_t quadrature;

    modport source (output valid, output in_phase, output quadrature, input ready);
    modport sink   (input valid, input in_phase, input quadrature, output ready);
endinterface

interface mps_decision_if import mps_pkg::*; ();
    logic    valid;
    logic    ready;
    symbol_t symbol;
    symbol_t sector;

    modport source (output valid, output symbol, output sector, input ready);
    modport sink   (input valid, input symbol, input sector, output ready);
endinterface

`default_nettype wire

[rtl/mps_apb_regs.sv]
// APB register file holding bits_per_symbol.
`default_nettype none

module mps_apb_regs import mps_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output bps_t                   bps
);

    bps_t bps_reg;
    logic hit;

    assign hit    = (paddr[APB_AW-1:2] == REG_BPS);
    assign pready = 1'b1;
    assign bps    = bps_reg;

    always_comb
    begin
        prdata = '0;
        if (hit)
        begin
            prdata = APB_DW'(bps_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bps_reg <= BPS_RESET;
        end
        else if (psel && penable && pwrite && hit)
        begin
            bps_reg <= pwdata[BPS_W-1:0];
        end
    end

endmodule

`default_nettype wire

[rtl/mps_cordic_pipe.sv]
// Prescale/pre-rotation stage followed by one CORDIC vectoring iteration per stage.
`default_nettype none

module mps_cordic_pipe import mps_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  sample_t      in_phase,
    input  sample_t      quadrature,
    output logic         out_valid,
    input  wire logic    out_ready,
    output cword_t       out_word
);

    localparam int NST = CORDIC_STEPS + 1;

    logic [NST-1:0]        v_reg;
    logic [NST-1:0]        en;
    logic signed [XW-1:0]  x_reg [NST];
    logic signed [XW-1:0]  y_reg [NST];
    cword_t                w_reg [NST];

    logic signed [XW-1:0]  xs;
    logic signed [XW-1:0]  ys;
    logic signed [XW-1:0]  x0_next;
    logic signed [XW-1:0]  y0_next;
    cword_t                w0_next;

    // per-stage enable: a stage moves when empty or when its successor moves
    genvar g;
    generate
        for (g = 0; g < NST - 1; g++)
        begin : g_en
            assign en[g] = !v_reg[g] || en[g+1];
        end
    endgenerate
    assign en[NST-1] = !v_reg[NST-1] || out_ready;

    assign in_ready  = en[0];
    assign out_valid = v_reg[NST-1];
    assign out_word  = w_reg[NST-1];

    always_comb
    begin
        xs = XW'(signed'({in_phase, {PRESCALE_SHIFT{1'b0}}}));
        ys = XW'(signed'({quadrature, {PRESCALE_SHIFT{1'b0}}}));
        w0_next.xzero = (in_phase == '0);
        w0_next.yneg  = quadrature[SAMPLE_WIDTH-1];
        if (in_phase[SAMPLE_WIDTH-1])
        begin
            x0_next   = -xs;
            y0_next   = -ys;
            w0_next.z = HALF_TURN_Z;
        end
        else
        begin
            x0_next   = xs;
            y0_next   = ys;
            w0_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg[0] <= x0_next;
            y_reg[0] <= y0_next;
            w_reg[0] <= w0_next;
        end
    end

    generate
        for (g = 0; g < CORDIC_STEPS; g++)
        begin : g_iter
            logic signed [XW-1:0] dx;
            logic signed [XW-1:0] dy;
            logic signed [XW-1:0] x_next;
            logic signed [XW-1:0] y_next;
            cword_t               w_next;

            always_comb
            begin
                dx     = y_reg[g] >>> g;
                dy     = x_reg[g] >>> g;
                w_next = w_reg[g];
                if (!y_reg[g][XW-1])
                begin
                    x_next   = x_reg[g] + dx;
                    y_next   = y_reg[g] - dy;
                    w_next.z = w_reg[g].z + ATAN_TAB[g];
                end
                else
                begin
                    x_next   = x_reg[g] - dx;
                    y_next   = y_reg[g] + dy;
                    w_next.z = w_reg[g].z - ATAN_TAB[g];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[g+1])
                begin
                    x_reg[g+1] <= x_next;
                    y_reg[g+1] <= y_next;
                    w_reg[g+1] <= w_next;
                end
            end
        end
    endgenerate

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&v_reg))
        else $error("input blocked while pipeline has a bubble");

    a_last_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[NST-1] && !out_ready) |=> (v_reg[NST-1] && $stable(w_reg[NST-1])))
        else $error("stalled last stage lost or changed its word");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v_reg[0])
        else $error("accepted word did not enter the first stage");

endmodule

`default_nettype wire

[rtl/mps_slicer.sv]
// Angle rounding, sector decision, Gray coding and the output register.
`default_nettype none

module mps_slicer import mps_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  cword_t       in_word,
    input  bps_t         bps,
    mps_decision_if.source decisions
);

    logic                 out_v_reg;
    symbol_t              symbol_reg;
    symbol_t              sector_reg;

    logic [ZW-1:0]        z_rnd;
    logic [ANGLE_W-1:0]   angle;
    bps_t                 b_clamp;
    logic [SHAMT_W-1:0]   half_sh;
    logic [SHAMT_W-1:0]   quot_sh;
    logic [ANGLE_W:0]     sum;
    logic [ANGLE_W:0]     quot;
    symbol_t              m_mask;
    symbol_t              sector_next;
    logic                 in_fire;

    assign in_ready         = !out_v_reg || decisions.ready;
    assign in_fire          = in_valid && in_ready;
    assign decisions.valid  = out_v_reg;
    assign decisions.symbol = symbol_reg;
    assign decisions.sector = sector_reg;

    always_comb
    begin
        z_rnd = in_word.z + Z_ROUND;
        if (in_word.xzero)
        begin
            angle = in_word.yneg ? ANGLE_3QUARTER : ANGLE_QUARTER;
        end
        else
        begin
            angle = z_rnd[ZW-1 -: ANGLE_W];
        end

        if (bps == '0)
        begin
            b_clamp = BPS_W'(1);
        end
        else if (bps > BPS_W'(MAX_BITS))
        begin
            b_clamp = BPS_W'(MAX_BITS);
        end
        else
        begin
            b_clamp = bps;
        end

        half_sh     = SHAMT_W'(ANGLE_W - 1) - SHAMT_W'(b_clamp);
        quot_sh     = SHAMT_W'(ANGLE_W) - SHAMT_W'(b_clamp);
        sum         = {1'b0, angle} + ((ANGLE_W + 1)'(1) << half_sh);
        quot        = sum >> quot_sh;
        m_mask      = MAX_BITS'(((MAX_BITS + 1)'(1) << b_clamp) - (MAX_BITS + 1)'(1));
        sector_next = quot[MAX_BITS-1:0] & m_mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sector_reg <= sector_next;
            symbol_reg <= sector_next ^ (sector_next >> 1);
        end
    end

    a_quarter_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_word.xzero && !in_word.yneg && (b_clamp >= BPS_W'(2)))
        |=> (sector_reg == (($past(m_mask) >> 2) + MAX_BITS'(1))))
        else $error("zero in-phase with positive quadrature not sliced to quarter turn");

endmodule

`default_nettype wire

[rtl/mpsk_phase_slicer.sv]
// Throughput: one word per cycle while decisions.ready is high; the prescale stage,
// 16 CORDIC iteration stages and the output register each hold one word, and bubbles
// collapse under stall.
// Reset (rst_n low, asynchronous): all valid bits clear, bits_per_symbol = 2.
// bits_per_symbol is read at the output stage; 0 acts as 1, above 6 acts as 6.
`default_nettype none

module mpsk_phase_slicer import mps_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    mps_sample_if.sink             samples,
    mps_decision_if.source         decisions
);

    bps_t   bps;
    logic   c_valid;
    logic   c_ready;
    cword_t c_word;

    mps_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .bps     (bps)
    );

    mps_cordic_pipe u_cordic (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (samples.valid),
        .in_ready   (samples.ready),
        .in_phase   (samples.in_phase),
        .quadrature (samples.quadrature),
        .out_valid  (c_valid),
        .out_ready  (c_ready),
        .out_word   (c_word)
    );

    mps_slicer u_slicer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_word   (c_word),
        .bps       (bps),
        .decisions (decisions)
    );

endmodule

`default_nettype wire
